// ===== design/srd_pkg.sv =====
// Shared types, constants and the CRC-16/XMODEM byte update for the scanner
// reply deframer. No dependencies.
`default_nettype none

package srd_pkg;

  // Header bytes that open the two frame types
  localparam logic [7:0] HdrCode = 8'h03;
  localparam logic [7:0] HdrResp = 8'h02;

  // CRC-16/XMODEM generator (x^16 + x^12 + x^5 + 1, top bit implicit)
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Payload bytes below this index are flagged as kept
  localparam logic [15:0] MaxCodeBytes = 16'd255;

  // Alarm length after reset
  localparam logic [7:0] AlarmTicksRst = 8'd2;

  // Input word kinds
  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef enum logic [2:0] {
    KindCode    = 3'd0,
    KindOk      = 3'd1,
    KindBadHdr  = 3'd2,
    KindZeroLen = 3'd3,
    KindCrcErr  = 3'd4,
    KindCleared = 3'd5
  } kind_e;

  // One accepted input word
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  // One result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       kept;
    logic       last;
    logic       alarm_active;
  } res_t;

  // MSB-first CRC update over one byte, eight shift steps
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/srd_in_reg.sv =====
// Input register of the scanner reply deframer: holds one word until the
// parser takes it. Depends on srd_pkg.
`default_nettype none

module srd_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           cmd_i,
  input  logic [7:0]     rx_byte_i,
  input  logic           take_i,
  output logic           valid_o,
  output srd_pkg::item_t item_o
);
  import srd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Free slot, or the held word leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd     <= cmd_i;
      item_q.rx_byte <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== design/srd_parser.sv =====
// Frame parser of the scanner reply deframer: phase machine, length and CRC
// tracking, alarm counter and the alarm_ticks register. Depends on srd_pkg.
`default_nettype none

module srd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           proc_i,
  input  srd_pkg::item_t item_i,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_data_i,
  output logic           res_valid_o,
  output srd_pkg::res_t  res_o
);
  import srd_pkg::*;

  typedef enum logic [9:0] {
    PhHunt     = 10'b00_0000_0001,
    PhLenHi    = 10'b00_0000_0010,
    PhLenLo    = 10'b00_0000_0100,
    PhPayload  = 10'b00_0000_1000,
    PhRespZero = 10'b00_0001_0000,
    PhCmd      = 10'b00_0010_0000,
    PhSize     = 10'b00_0100_0000,
    PhData     = 10'b00_1000_0000,
    PhCrcHi    = 10'b01_0000_0000,
    PhCrcLo    = 10'b10_0000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] remaining_q, remaining_d;
  logic [15:0] pay_idx_q, pay_idx_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [7:0]  reply_code_q, reply_code_d;
  logic [7:0]  alarm_cnt_q, alarm_cnt_d;
  logic [7:0]  alarm_ticks_q;

  logic [7:0]  reload;
  logic [7:0]  b;
  logic [15:0] crc_next;
  logic [15:0] rem_dec;
  logic [15:0] len_word;
  logic        res_valid;
  kind_e       res_kind;
  logic [7:0]  res_data;
  logic        res_kept;
  logic        res_last;

  // Zero in the register still gives a one-tick alarm
  assign reload   = (alarm_ticks_q != 8'd0) ? alarm_ticks_q : 8'd1;
  assign b        = item_i.rx_byte;
  assign crc_next = crc16_update(crc_q, b);
  assign rem_dec  = (remaining_q != 16'd0) ? remaining_q - 16'd1 : 16'd0;
  assign len_word = {remaining_q[15:8], b};

  // Next state and result for the word in the input register
  always_comb begin
    phase_d      = phase_q;
    remaining_d  = remaining_q;
    pay_idx_d    = pay_idx_q;
    crc_d        = crc_q;
    crc_hi_d     = crc_hi_q;
    reply_code_d = reply_code_q;
    alarm_cnt_d  = alarm_cnt_q;
    res_valid    = 1'b0;
    res_kind     = KindCode;
    res_data     = 8'h00;
    res_kept     = 1'b0;
    res_last     = 1'b0;

    if (item_i.cmd == CmdTick) begin
      // poll tick: count the alarm down
      if (alarm_cnt_q != 8'd0) begin
        alarm_cnt_d = alarm_cnt_q - 8'd1;
        if (alarm_cnt_q == 8'd1) begin
          res_valid = 1'b1;
          res_kind  = KindCleared;
        end
      end
    end else if (alarm_cnt_q != 8'd0) begin
      // byte during alarm: drop it and restart the period
      alarm_cnt_d = reload;
    end else begin
      case (phase_q)
        PhLenHi: begin
          remaining_d = {b, 8'h00};
          phase_d     = PhLenLo;
        end
        PhLenLo: begin
          remaining_d = len_word;
          if (len_word == 16'd0) begin
            alarm_cnt_d = reload;
            phase_d     = PhHunt;
            res_valid   = 1'b1;
            res_kind    = KindZeroLen;
          end else begin
            pay_idx_d = 16'd0;
            phase_d   = PhPayload;
          end
        end
        PhPayload: begin
          res_valid   = 1'b1;
          res_kind    = KindCode;
          res_data    = b;
          res_kept    = (pay_idx_q < MaxCodeBytes);
          res_last    = (remaining_q <= 16'd1);
          pay_idx_d   = (pay_idx_q != 16'hFFFF) ? pay_idx_q + 16'd1 : pay_idx_q;
          remaining_d = rem_dec;
          if (rem_dec == 16'd0) begin
            phase_d = PhHunt;
          end
        end
        PhRespZero: begin
          if (b != 8'h00) begin
            alarm_cnt_d = reload;
            phase_d     = PhHunt;
            res_valid   = 1'b1;
            res_kind    = KindBadHdr;
          end else begin
            crc_d   = 16'h0000;
            phase_d = PhCmd;
          end
        end
        PhCmd: begin
          reply_code_d = b;
          crc_d        = crc_next;
          phase_d      = PhSize;
        end
        PhSize: begin
          remaining_d = {8'h00, b};
          crc_d       = crc_next;
          phase_d     = (b != 8'h00) ? PhData : PhCrcHi;
        end
        PhData: begin
          crc_d       = crc_next;
          remaining_d = rem_dec;
          if (rem_dec == 16'd0) begin
            phase_d = PhCrcHi;
          end
        end
        PhCrcHi: begin
          crc_hi_d = b;
          phase_d  = PhCrcLo;
        end
        PhCrcLo: begin
          phase_d   = PhHunt;
          res_valid = 1'b1;
          if ({crc_hi_q, b} == crc_q) begin
            res_kind = KindOk;
            res_data = reply_code_q;
          end else begin
            res_kind = KindCrcErr;
          end
        end
        default: begin
          // hunting, and any stray phase code
          if (b == HdrCode) begin
            phase_d = PhLenHi;
          end else if (b == HdrResp) begin
            phase_d = PhRespZero;
          end else begin
            alarm_cnt_d = reload;
            phase_d     = PhHunt;
            res_valid   = 1'b1;
            res_kind    = KindBadHdr;
          end
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      remaining_q  <= 16'd0;
      pay_idx_q    <= 16'd0;
      crc_q        <= 16'd0;
      crc_hi_q     <= 8'd0;
      reply_code_q <= 8'd0;
      alarm_cnt_q  <= 8'd0;
    end else if (proc_i) begin
      phase_q      <= phase_d;
      remaining_q  <= remaining_d;
      pay_idx_q    <= pay_idx_d;
      crc_q        <= crc_d;
      crc_hi_q     <= crc_hi_d;
      reply_code_q <= reply_code_d;
      alarm_cnt_q  <= alarm_cnt_d;
    end
  end

  // alarm_ticks register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_ticks_q <= AlarmTicksRst;
    end else if (cfg_we_i) begin
      alarm_ticks_q <= cfg_data_i;
    end
  end

  assign res_valid_o        = res_valid;
  assign res_o.kind         = res_kind;
  assign res_o.data         = res_data;
  assign res_o.kept         = res_kept;
  assign res_o.last         = res_last;
  assign res_o.alarm_active = (alarm_cnt_d != 8'd0);

  // Alarm cleared word leaves the counter at zero
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && res_valid && res_kind == KindCleared |=> alarm_cnt_q == 8'd0)
    else $error("alarm cleared but counter not zero");

  // Header errors start an alarm and send the parser back to hunting
  a_err_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && res_valid && (res_kind == KindBadHdr || res_kind == KindZeroLen)
    |=> alarm_cnt_q != 8'd0 && phase_q == PhHunt)
    else $error("header error without alarm");

  // Bytes that arrive during an alarm yield nothing
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && item_i.cmd == CmdByte && alarm_cnt_q != 8'd0 |-> !res_valid)
    else $error("result from a dropped byte");

  // Parser never moves while no word is processed
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc_i |=> $stable(phase_q) && $stable(alarm_cnt_q))
    else $error("state moved without a word");

endmodule

`default_nettype wire

// ===== design/srd_out_reg.sv =====
// Result register of the scanner reply deframer: holds one result word until
// the consumer takes it. Depends on srd_pkg.
`default_nettype none

module srd_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic          res_valid_i,
  input  srd_pkg::res_t res_i,
  output logic          can_load_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output srd_pkg::res_t res_o
);
  import srd_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Room when empty or the held word is taken this cycle
  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/scanner_reply_deframer_top.sv =====
// Scanner reply deframer top level: input register, frame parser and result
// register. Depends on srd_pkg, srd_in_reg, srd_parser and srd_out_reg.
//
// Takes one word per cycle (a received byte or a poll tick) while results are
// taken, and gives at most one result word per input word. A word waits in the
// input register until the result register has room, is then parsed, and its
// result is shown from the result register; as each register holds one word,
// the block keeps taking a word every cycle while results are taken every
// cycle. Code frame payload bytes come out as code words with kept and last
// flags; responses give their command or a CRC error; header errors start an
// alarm that drops bytes until alarm_ticks poll ticks pass with no byte. The
// alarm_ticks register is written through the cfg channel and is always ready.
`default_nettype none

module scanner_reply_deframer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_o,
  output logic       kept_o,
  output logic       last_o,
  output logic       alarm_active_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  import srd_pkg::*;

  logic  item_valid;
  item_t item;
  logic  can_load;
  logic  proc;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  // Parse when a word is held and the result register has room
  assign proc        = item_valid && can_load;
  assign cfg_ready_o = 1'b1;

  srd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .rx_byte_i  (rx_byte_i),
    .take_i     (proc),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  srd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (proc),
    .item_i      (item),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  srd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (proc),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign data_o         = out_res.data;
  assign kept_o         = out_res.kept;
  assign last_o         = out_res.last;
  assign alarm_active_o = out_res.alarm_active;

endmodule

`default_nettype wire
